[design/assert_macros.svh]
// assertion macros for the port-level checker in rwcs_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rwcs_pkg.sv]
// shared types and constants for the riff/wave chunk scanner
// no dependencies; used by the scanner and its checker
package rwcs_pkg;

    localparam int unsigned OFFSET_BITS_DEF = 32;
    localparam int unsigned OUT_WIDTH       = 32;

    // chunk and signature ids, little-endian as they sit in the header word
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam int unsigned RIFF_LAST_IDX   = 3;
    localparam int unsigned FILE_HEADER_LEN = 12;
    localparam logic [31:0] MIN_FMT_SIZE    = 32'd16;
    localparam logic [15:0] TAG_PCM         = 16'd1;
    localparam logic [15:0] TAG_MP3         = 16'd85;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT_HDR = 4'd1,
        ST_NO_RIFF   = 4'd2,
        ST_NO_WAVE   = 4'd3,
        ST_TRUNC_HDR = 4'd4,
        ST_BEYOND    = 4'd5,
        ST_FMT_SMALL = 4'd6,
        ST_NO_FMT    = 4'd7,
        ST_NO_DATA   = 4'd8,
        ST_BAD_TAG   = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        PH_FILE_HDR  = 2'd0,
        PH_CHUNK_HDR = 2'd1,
        PH_BODY      = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CK_OTHER = 2'd0,
        CK_FMT   = 2'd1,
        CK_DATA  = 2'd2
    } chunk_kind_t;

endpackage

[design/riff_wave_chunk_scanner.sv]
// riff/wave chunk scanner, top level
// depends on rwcs_pkg; checker attached by bind in rwcs_checker.sv
//
// Scans a RIFF/WAVE file that streams in one byte per transaction, with
// s_last_byte on the final byte. It checks the "RIFF" and "WAVE" signatures,
// walks the chunk headers and even-padded bodies, keeps the format tag of the
// last "fmt " chunk and the place and size of the first non-empty "data" chunk,
// and latches the first error in file order. Only the final byte of a file
// produces a result transaction: a status code, and on success either the
// whole file (tag 1, encoding 0) or the data chunk's offset and length
// (tag 85, encoding 1). The RIFF size field is ignored. One byte is taken every
// clock: each byte needs only a position increment, a header shift, a body
// countdown and a few compares, all done in the cycle the byte is accepted.
// The registered result shows on the m_ port in the cycle after the last byte;
// the next file may start in that same cycle, and input stalls only while a
// result waits for m_ready. OFFSET_BITS sets the byte position counter; a file of
// 2^OFFSET_BITS bytes or more reports "chunk beyond payload" unless an earlier
// error was found. All parser state returns to its reset values after each
// last byte.
module riff_wave_chunk_scanner #(
    parameter int unsigned OFFSET_BITS = rwcs_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_encoding,
    output logic [15:0] m_format_tag,
    output logic [31:0] m_out_offset,
    output logic [31:0] m_out_length
);
    import rwcs_pkg::*;

    // parser state
    logic [OFFSET_BITS-1:0] pos_reg,        pos_next;
    phase_t                 phase_reg,      phase_next;
    logic [63:0]            hdr_shift_reg,  hdr_shift_next;
    logic [2:0]             hdr_cnt_reg,    hdr_cnt_next;    // chunk header bytes so far
    logic [32:0]            body_left_reg,  body_left_next;  // padded body bytes left
    logic [1:0]             body_idx_reg,   body_idx_next;   // body bytes seen, saturates at 2
    chunk_kind_t            kind_reg,       kind_next;
    logic [15:0]            tag_reg,        tag_next;
    logic                   tag_seen_reg,   tag_seen_next;
    logic                   data_seen_reg,  data_seen_next;
    logic [OFFSET_BITS-1:0] data_start_reg, data_start_next;
    logic [31:0]            data_len_reg,   data_len_next;
    status_t                err_reg,        err_next;
    logic                   small_fmt_reg,  small_fmt_next;

    // result register
    logic        m_valid_reg;
    status_t     m_status_reg,   m_status_next;
    logic        m_encoding_reg, m_encoding_next;
    logic [15:0] m_tag_reg;
    logic [31:0] m_offset_reg,   m_offset_next;
    logic [31:0] m_length_reg,   m_length_next;

    logic accept;

    // a new byte may enter whenever the result slot is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // per-byte parse step plus the end-of-file verdict
    always_comb begin
        logic [63:0] shifted;
        logic [31:0] chunk_id;
        logic [31:0] size_word;
        logic        is_small;

        pos_next        = pos_reg;
        phase_next      = phase_reg;
        hdr_shift_next  = hdr_shift_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        body_left_next  = body_left_reg;
        body_idx_next   = body_idx_reg;
        kind_next       = kind_reg;
        tag_next        = tag_reg;
        tag_seen_next   = tag_seen_reg;
        data_seen_next  = data_seen_reg;
        data_start_next = data_start_reg;
        data_len_next   = data_len_reg;
        err_next        = err_reg;
        small_fmt_next  = small_fmt_reg;

        shifted    = {s_data_byte, hdr_shift_reg[63:8]};
        chunk_id   = shifted[31:0];
        size_word  = shifted[63:32];
        is_small   = (chunk_id == ID_FMT) && (size_word < MIN_FMT_SIZE);

        if (pos_reg == '1) begin
            // position counter saturated: file too long
            if (err_reg == ST_OK) begin
                err_next = ST_BEYOND;
            end
        end else begin
            pos_next = pos_reg + OFFSET_BITS'(1);
            if (err_reg == ST_OK) begin
                unique case (phase_reg)
                    PH_FILE_HDR: begin
                        hdr_shift_next = shifted;
                        if (pos_reg == OFFSET_BITS'(RIFF_LAST_IDX)
                            && shifted[63:32] != ID_RIFF) begin
                            err_next = ST_NO_RIFF;
                        end
                        if (pos_reg == OFFSET_BITS'(FILE_HEADER_LEN - 1)) begin
                            if (shifted[63:32] != ID_WAVE) begin
                                err_next = ST_NO_WAVE;
                            end
                            phase_next   = PH_CHUNK_HDR;
                            hdr_cnt_next = '0;
                        end
                    end
                    PH_CHUNK_HDR: begin
                        hdr_shift_next = shifted;
                        if (hdr_cnt_reg == 3'd7) begin
                            // eighth header byte: id and size complete
                            if (chunk_id == ID_FMT) begin
                                kind_next = CK_FMT;
                            end else if (chunk_id == ID_DATA) begin
                                kind_next = CK_DATA;
                            end else begin
                                kind_next = CK_OTHER;
                            end
                            if ((chunk_id == ID_FMT) && !is_small) begin
                                tag_seen_next = 1'b1;
                            end
                            if ((chunk_id == ID_DATA) && (size_word != '0)
                                && !data_seen_reg) begin
                                data_seen_next  = 1'b1;
                                data_start_next = pos_reg + OFFSET_BITS'(1);
                                data_len_next   = size_word;
                            end
                            body_idx_next = '0;
                            hdr_cnt_next  = '0;
                            if (size_word == '0) begin
                                // empty body closes the chunk at once
                                phase_next     = PH_CHUNK_HDR;
                                body_left_next = '0;
                                small_fmt_next = 1'b0;
                                if (is_small) begin
                                    err_next = ST_FMT_SMALL;
                                end
                            end else begin
                                phase_next     = PH_BODY;
                                body_left_next = {1'b0, size_word} + 33'(size_word[0]);
                                small_fmt_next = is_small;
                            end
                        end else begin
                            hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        end
                    end
                    PH_BODY: begin
                        // format tag is the first two body bytes, little-endian
                        if (kind_reg == CK_FMT && !small_fmt_reg) begin
                            if (body_idx_reg == 2'd0) begin
                                tag_next[7:0] = s_data_byte;
                            end else if (body_idx_reg == 2'd1) begin
                                tag_next[15:8] = s_data_byte;
                            end
                        end
                        if (body_idx_reg != 2'd2) begin
                            body_idx_next = body_idx_reg + 2'd1;
                        end
                        body_left_next = body_left_reg - 33'd1;
                        if (body_left_reg == 33'd1) begin
                            phase_next     = PH_CHUNK_HDR;
                            hdr_cnt_next   = '0;
                            small_fmt_next = 1'b0;
                            if (small_fmt_reg) begin
                                err_next = ST_FMT_SMALL;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        // verdict, meaningful only on the last byte
        priority if (pos_next < OFFSET_BITS'(FILE_HEADER_LEN)) begin
            m_status_next = ST_SHORT_HDR;
        end else if (err_next != ST_OK) begin
            m_status_next = err_next;
        end else if (phase_next == PH_CHUNK_HDR && hdr_cnt_next != '0) begin
            m_status_next = ST_TRUNC_HDR;
        end else if (phase_next == PH_BODY) begin
            m_status_next = ST_BEYOND;
        end else if (!tag_seen_next) begin
            m_status_next = ST_NO_FMT;
        end else if (!data_seen_next) begin
            m_status_next = ST_NO_DATA;
        end else if (tag_next != TAG_PCM && tag_next != TAG_MP3) begin
            m_status_next = ST_BAD_TAG;
        end else begin
            m_status_next = ST_OK;
        end

        m_encoding_next = 1'b0;
        m_offset_next   = '0;
        m_length_next   = '0;
        if (m_status_next == ST_OK) begin
            if (tag_next == TAG_PCM) begin
                m_length_next = OUT_WIDTH'(pos_next);
            end else begin
                m_encoding_next = 1'b1;
                m_offset_next   = OUT_WIDTH'(data_start_next);
                m_length_next   = data_len_next;
            end
        end
    end

    // parser state register; each last byte returns it to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            pos_reg        <= '0;
            phase_reg      <= PH_FILE_HDR;
            hdr_shift_reg  <= '0;
            hdr_cnt_reg    <= '0;
            body_left_reg  <= '0;
            body_idx_reg   <= '0;
            kind_reg       <= CK_OTHER;
            tag_reg        <= '0;
            tag_seen_reg   <= 1'b0;
            data_seen_reg  <= 1'b0;
            data_start_reg <= '0;
            data_len_reg   <= '0;
            err_reg        <= ST_OK;
            small_fmt_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            hdr_shift_reg  <= hdr_shift_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            body_left_reg  <= body_left_next;
            body_idx_reg   <= body_idx_next;
            kind_reg       <= kind_next;
            tag_reg        <= tag_next;
            tag_seen_reg   <= tag_seen_next;
            data_seen_reg  <= data_seen_next;
            data_start_reg <= data_start_next;
            data_len_reg   <= data_len_next;
            err_reg        <= err_next;
            small_fmt_reg  <= small_fmt_next;
        end
    end

    // result register: loaded on the last byte, held until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            m_status_reg   <= m_status_next;
            m_encoding_reg <= m_encoding_next;
            m_tag_reg      <= tag_next;
            m_offset_reg   <= m_offset_next;
            m_length_reg   <= m_length_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_encoding   = m_encoding_reg;
    assign m_format_tag = m_tag_reg;
    assign m_out_offset = m_offset_reg;
    assign m_out_length = m_length_reg;

endmodule

[design/rwcs_checker.sv]
// port-level checker for the riff/wave chunk scanner, bound to the top level
// depends on rwcs_pkg and assert_macros.svh
`include "assert_macros.svh"

module rwcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic        m_encoding,
    input logic [15:0] m_format_tag,
    input logic [31:0] m_out_offset,
    input logic [31:0] m_out_length
);
    import rwcs_pkg::*;

    // a stalled result holds its value
    `ASSERT_NXT(a_hold, aclk, aresetn, (m_valid && !m_ready), (m_valid && $stable(m_status) && $stable(m_out_offset) && $stable(m_out_length)), "result changed while stalled")

    // a result appears only after a last byte was taken
    `ASSERT_IMP(a_cause, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready && s_last_byte), "result without a last byte")

    // failed files carry no range
    `ASSERT_IMP(a_err_range, aclk, aresetn, (m_valid && m_status != ST_OK), (!m_encoding && m_out_offset == '0 && m_out_length == '0), "range on an error")

    // encoding follows the kept format tag
    `ASSERT_IMP(a_pcm, aclk, aresetn, (m_valid && m_status == ST_OK && !m_encoding), (m_format_tag == TAG_PCM && m_out_offset == '0), "whole-file result without pcm tag")

    `ASSERT_IMP(a_mp3, aclk, aresetn, (m_valid && m_encoding), (m_status == ST_OK && m_format_tag == TAG_MP3), "data-chunk result without mp3 tag")

endmodule

bind riff_wave_chunk_scanner rwcs_checker u_rwcs_checker (.*);

[tb/wave_scan_checker.sv]
// result checker for the riff/wave chunk scanner testbench
// depends on rwcs_pkg; watches both channels, predicts each file's result and compares
module wave_scan_checker #(
    parameter int unsigned POS_BITS = rwcs_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_status,
    input  logic        m_encoding,
    input  logic [15:0] m_format_tag,
    input  logic [31:0] m_out_offset,
    input  logic [31:0] m_out_length,
    output int          fail_count,
    output int          pending_count,
    output logic [9:0]  status_hit
);
    import rwcs_pkg::*;

    localparam logic [31:0] POS_LIMIT = 32'((64'd1 << POS_BITS) - 64'd1);

    typedef struct packed {
        status_t     status;
        logic        encoding;
        logic [15:0] fmt_tag;
        logic [31:0] offset;
        logic [31:0] length;
    } scan_report_t;

    scan_report_t expected_reports[$];
    int           mismatches = 0;
    logic [9:0]   hit_mask = '0;

    // parser image
    logic [31:0] byte_count;
    phase_t      phase;
    logic [63:0] hdr_window;
    logic [32:0] chunk_left;
    chunk_kind_t kind;
    logic [15:0] tag;
    logic        tag_valid;
    logic        data_valid;
    logic [31:0] data_pos;
    logic [31:0] data_bytes;
    status_t     first_fault;
    logic        fmt_too_small;

    function automatic void clear_scan_state();
        byte_count    = '0;
        phase         = PH_FILE_HDR;
        hdr_window    = '0;
        chunk_left    = '0;
        kind          = CK_OTHER;
        tag           = '0;
        tag_valid     = 1'b0;
        data_valid    = 1'b0;
        data_pos      = '0;
        data_bytes    = '0;
        first_fault   = ST_OK;
        fmt_too_small = 1'b0;
    endfunction

    function automatic void note_fault(input status_t code);
        if (first_fault == ST_OK)
            first_fault = code;
    endfunction

    function automatic logic [32:0] padded_body();
        logic [32:0] sz;
        sz = {1'b0, hdr_window[63:32]};
        return sz + {32'd0, sz[0]};
    endfunction

    function automatic void close_chunk();
        phase      = PH_CHUNK_HDR;
        chunk_left = '0;
        if (fmt_too_small)
            note_fault(ST_FMT_SMALL);
        fmt_too_small = 1'b0;
    endfunction

    function automatic void scan_payload_byte(input logic [7:0] b, input logic [31:0] idx);
        logic [32:0] k;
        if (phase != PH_BODY)
            hdr_window = {b, hdr_window[63:8]};
        case (phase)
            PH_FILE_HDR: begin
                if (idx == RIFF_LAST_IDX && hdr_window[63:32] != ID_RIFF)
                    note_fault(ST_NO_RIFF);
                if (idx == FILE_HEADER_LEN - 1) begin
                    if (hdr_window[63:32] != ID_WAVE)
                        note_fault(ST_NO_WAVE);
                    phase      = PH_CHUNK_HDR;
                    chunk_left = '0;
                end
            end
            PH_CHUNK_HDR: begin
                chunk_left = chunk_left + 33'd1;
                if (chunk_left >= 33'd8) begin
                    kind = (hdr_window[31:0] == ID_FMT)  ? CK_FMT  :
                           (hdr_window[31:0] == ID_DATA) ? CK_DATA : CK_OTHER;
                    fmt_too_small = (kind == CK_FMT) && (hdr_window[63:32] < MIN_FMT_SIZE);
                    if (kind == CK_FMT && !fmt_too_small)
                        tag_valid = 1'b1;
                    if (kind == CK_DATA && hdr_window[63:32] != 0 && !data_valid) begin
                        data_valid = 1'b1;
                        data_pos   = idx + 32'd1;
                        data_bytes = hdr_window[63:32];
                    end
                    chunk_left = padded_body();
                    phase      = PH_BODY;
                    if (chunk_left == 0)
                        close_chunk();
                end
            end
            default: begin
                // tag sits in the first two body bytes of a full-size fmt chunk
                if (kind == CK_FMT && !fmt_too_small) begin
                    k = padded_body() - chunk_left;
                    if (k == 0)
                        tag[7:0] = b;
                    else if (k == 1)
                        tag[15:8] = b;
                end
                if (chunk_left != 0)
                    chunk_left = chunk_left - 33'd1;
                if (chunk_left == 0)
                    close_chunk();
            end
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic [31:0]  idx;
        logic [31:0]  len;
        scan_report_t r;
        idx = byte_count;
        // position counter saturates, which counts as running past the payload
        if (idx >= POS_LIMIT) begin
            note_fault(ST_BEYOND);
        end else begin
            byte_count = idx + 32'd1;
            if (first_fault == ST_OK)
                scan_payload_byte(b, idx);
        end
        if (!last)
            return;
        len = byte_count;
        r   = '0;
        if (len < FILE_HEADER_LEN)
            r.status = ST_SHORT_HDR;
        else if (first_fault != ST_OK)
            r.status = first_fault;
        else if (phase == PH_CHUNK_HDR && chunk_left != 0)
            r.status = ST_TRUNC_HDR;
        else if (phase == PH_BODY)
            r.status = ST_BEYOND;
        else if (!tag_valid)
            r.status = ST_NO_FMT;
        else if (!data_valid)
            r.status = ST_NO_DATA;
        else if (tag != TAG_PCM && tag != TAG_MP3)
            r.status = ST_BAD_TAG;
        else
            r.status = ST_OK;
        r.fmt_tag = tag;
        if (r.status == ST_OK) begin
            if (tag == TAG_PCM) begin
                r.length = len;
            end else begin
                r.encoding = 1'b1;
                r.offset   = data_pos;
                r.length   = data_bytes;
            end
        end
        expected_reports.push_back(r);
        hit_mask[r.status] = 1'b1;
        clear_scan_state();
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        scan_report_t want;
        if (!aresetn) begin
            clear_scan_state();
            expected_reports.delete();
            hit_mask = '0;
        end else begin
            if (s_valid && s_ready)
                predict_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected nothing, got status %0d",
                             $time, m_status);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("encoding", want.encoding, m_encoding);
                    check_field("tag", want.fmt_tag, m_format_tag);
                    check_field("out_offset", want.offset, m_out_offset);
                    check_field("out_length", want.length, m_out_length);
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_reports.size();
        status_hit    <= hit_mask;
    end

endmodule

[tb/tb_riff_wave_chunk_scanner.sv]
// testbench top for the riff/wave chunk scanner
// depends on rwcs_pkg, riff_wave_chunk_scanner and wave_scan_checker
module tb_riff_wave_chunk_scanner;
    import rwcs_pkg::*;

    // narrowed position counter for the block under test
    localparam int unsigned POS_BITS    = 16;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_BYTES  = 1100;
    localparam int          RAND_FILES  = 16;
    localparam logic [31:0] ID_JUNK     = 32'h6B6E_756A;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [3:0]  m_status;
    logic        m_encoding;
    logic [15:0] m_format_tag;
    logic [31:0] m_out_offset;
    logic [31:0] m_out_length;

    int          fail_count;
    int          pending_count;
    logic [9:0]  status_hit;

    // idle knobs, percent of cycles
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    // long result-side hold-offs: requested by stimulus, served by the receiver
    int          hold_requests = 0;
    int          hold_served   = 0;

    int          files_sent    = 0;
    int          bytes_sent    = 0;
    logic [7:0]  file_bytes[$];

    riff_wave_chunk_scanner #(
        .OFFSET_BITS(POS_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_encoding  (m_encoding),
        .m_format_tag(m_format_tag),
        .m_out_offset(m_out_offset),
        .m_out_length(m_out_length)
    );

    wave_scan_checker #(
        .POS_BITS(POS_BITS)
    ) u_checker (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // file builders, all append to file_bytes
    // ---------------------------------------------------------------

    // little-endian word, as ids and sizes sit in the file
    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic logic [31:0] flip_bit(input logic [31:0] w);
        return w ^ (32'd1 << $urandom_range(31));
    endfunction

    // signature, riff size (ignored by the block), form type
    function automatic void put_file_header(input logic riff_ok, input logic wave_ok);
        put_word(riff_ok ? ID_RIFF : flip_bit(ID_RIFF));
        put_word($urandom());
        put_word(wave_ok ? ID_WAVE : flip_bit(ID_WAVE));
    endfunction

    // header plus body_len body bytes; the first two body bytes carry tag
    function automatic void put_chunk(input logic [31:0] id, input logic [31:0] size,
                                      input int body_len, input logic [15:0] tag);
        put_word(id);
        put_word(size);
        for (int i = 0; i < body_len; i++)
            file_bytes.push_back(i == 0 ? tag[7:0] : (i == 1 ? tag[15:8] : 8'($urandom())));
    endfunction

    // even-padded body length, small sizes only
    function automatic int padded(input logic [31:0] size);
        return int'(size + {31'd0, size[0]});
    endfunction

    function automatic logic [31:0] pick_fmt_size();
        case ($urandom_range(9))
            0:       return $urandom_range(15);
            1, 2:    return $urandom_range(17, 40);
            default: return 32'd16;
        endcase
    endfunction

    function automatic logic [15:0] pick_tag();
        case ($urandom_range(5))
            0, 1:    return TAG_PCM;
            2, 3:    return TAG_MP3;
            4:       return 16'($urandom());
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic void put_some_chunk(input chunk_kind_t kind);
        logic [31:0] sz;
        case (kind)
            CK_FMT: begin
                sz = pick_fmt_size();
                put_chunk(ID_FMT, sz, padded(sz), pick_tag());
            end
            CK_DATA: begin
                sz = ($urandom_range(5) == 0) ? 32'd0 : $urandom_range(1, 12);
                put_chunk(ID_DATA, sz, padded(sz), 16'($urandom()));
            end
            default: begin
                sz = $urandom_range(12);
                put_chunk(32'($urandom()), sz, padded(sz), 16'($urandom()));
            end
        endcase
    endfunction

    // mostly well-formed files with random content, some broken, some noise
    function automatic void build_random_file();
        int shape;
        int pos;
        shape = $urandom_range(99);
        if (shape >= 88) begin
            if ($urandom_range(1))
                put_word(ID_RIFF);
            repeat ($urandom_range(1, 30))
                file_bytes.push_back(8'($urandom()));
            return;
        end
        put_file_header($urandom_range(39) != 0, $urandom_range(39) != 0);
        if ($urandom_range(3) != 0) begin
            // usual layout with optional extra chunks around fmt and data
            if ($urandom_range(2) == 0)
                put_some_chunk(CK_OTHER);
            put_some_chunk(CK_FMT);
            if ($urandom_range(2) == 0)
                put_some_chunk(CK_OTHER);
            put_some_chunk(CK_DATA);
            if ($urandom_range(3) == 0)
                put_some_chunk(chunk_kind_t'($urandom_range(2)));
        end else begin
            repeat ($urandom_range(4))
                put_some_chunk(chunk_kind_t'($urandom_range(2)));
        end
        if (shape >= 70) begin
            case ($urandom_range(2))
                // cut short somewhere
                0: repeat ($urandom_range(1, file_bytes.size() - 1))
                    file_bytes.pop_back();
                // dangling partial chunk header
                1: repeat ($urandom_range(1, 7))
                    file_bytes.push_back(8'($urandom()));
                // one corrupted bit anywhere
                default: begin
                    pos = $urandom_range(file_bytes.size() - 1);
                    file_bytes[pos] ^= 8'(1 << $urandom_range(7));
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    task automatic push_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            push_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
        bytes_sent += file_bytes.size();
        file_bytes.delete();
    endtask

    // sender goes quiet until every predicted result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls, plus long hold-offs on request
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge aclk);
                hold_served++;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and verdict
    // ---------------------------------------------------------------
    initial begin
        int phase_files;
        int phase_bytes;

        repeat (2)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed files, no idling

        // pcm: whole payload comes back
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_PCM);
        put_chunk(ID_DATA, 4, 4, 16'h0000);
        send_file();
        // mp3 behind an unknown odd chunk; empty data chunk skipped, odd data padded
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_JUNK, 3, 4, 16'h0000);
        put_chunk(ID_FMT, 18, 18, TAG_MP3);
        put_chunk(ID_DATA, 0, 0, 16'h0000);
        put_chunk(ID_DATA, 5, 6, 16'h0000);
        put_chunk(ID_DATA, 2, 2, 16'h0000);
        send_file();
        // short payload wins over a signature that is already wrong
        put_word(flip_bit(ID_RIFF));
        repeat (3)
            file_bytes.push_back(8'hFF);
        send_file();
        // single byte payload
        file_bytes.push_back(8'h00);
        send_file();
        // one byte short of a full file header
        put_file_header(1'b1, 1'b1);
        void'(file_bytes.pop_back());
        send_file();
        // bad riff signature in a file that would otherwise pass
        put_file_header(1'b0, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_PCM);
        put_chunk(ID_DATA, 4, 4, 16'h0000);
        send_file();
        // bad wave form type
        put_file_header(1'b1, 1'b0);
        send_file();
        // header alone: no fmt
        put_file_header(1'b1, 1'b1);
        send_file();
        // chunk header cut after five bytes
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_PCM);
        put_word(ID_DATA);
        file_bytes.push_back(8'h04);
        send_file();
        // data body runs past the end
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_PCM);
        put_chunk(ID_DATA, 10, 4, 16'h0000);
        send_file();
        // largest size field
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_MP3);
        put_chunk(ID_DATA, 32'hFFFF_FFFF, 3, 16'h0000);
        send_file();
        // undersized fmt with its padded body complete
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 15, 16, TAG_PCM);
        put_chunk(ID_DATA, 4, 4, 16'h0000);
        send_file();
        // undersized fmt, payload ends inside its body
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 14, 6, TAG_PCM);
        send_file();
        // data without fmt
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_DATA, 4, 4, 16'h0000);
        send_file();
        // fmt with only an empty data chunk
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_PCM);
        put_chunk(ID_DATA, 0, 0, 16'h0000);
        send_file();
        // unsupported tag
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, 16'hFFFF);
        put_chunk(ID_DATA, 4, 4, 16'h0000);
        send_file();
        // the last fmt chunk decides the tag
        put_file_header(1'b1, 1'b1);
        put_chunk(ID_FMT, 16, 16, TAG_MP3);
        put_chunk(ID_DATA, 3, 4, 16'h0000);
        put_chunk(ID_FMT, 16, 16, TAG_PCM);
        send_file();
        wait_drained();

        // random files in four idling phases, draining between them
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                    // result side holds off while files keep coming, input backs up
                    hold_requests <= hold_requests + 1;
                end
                1: begin
                    tx_idle_pct = 88;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 88;
                end
                default: begin
                    tx_idle_pct = 33;
                    rx_stall_pct <= 33;
                end
            endcase
            phase_files = files_sent;
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < RAND_BYTES / 4 ||
                   files_sent - phase_files < RAND_FILES / 4) begin
                build_random_file();
                send_file();
            end
            wait_drained();
        end

        // let any stray result show up
        repeat (20)
            @(posedge aclk);

        $display("covered %0d files in %0d bytes: directed cases plus random files",
                 files_sent, bytes_sent);
        $display("under four stall patterns; status codes seen, one bit per code: %b",
                 status_hit);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_count);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
